FILE: sv/atan2_bucket_approximation_macros.svh
// Assertion macros shared by the atan2 bucket approximation RTL.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ATAN2_BUCKET_APPROXIMATION_MACROS_SVH
`define ATAN2_BUCKET_APPROXIMATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define A2B_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("a2b same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define A2B_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("a2b next-cycle check failed");

`endif

FILE: sv/a2b_pkg.sv
// Types, ratio ladder and angle tables for the atan2 bucket approximation.
// No dependencies.
package a2b_pkg;

  localparam int A2B_CELLS    = 9;
  localparam int A2B_BUCKET_W = 4;
  localparam int A2B_ANGLE_W  = 13;
  localparam int A2B_OUT_TDATA_W = 16;

  // Control word handed down the cell row with each item.
  typedef struct packed {
    logic                    opp_pos;
    logic                    adj_pos;
    logic                    adj_zero;
    logic                    opp_zero;
    logic                    steep;     // opposite magnitude >= adjacent magnitude
    logic [A2B_BUCKET_W-1:0] bucket;
  } a2b_ctl_t;

  localparam logic [9:0] A2B_LADDER [A2B_CELLS] =
    '{10'd35, 10'd42, 10'd51, 10'd62, 10'd78, 10'd102, 10'd145, 10'd244, 10'd733};

  localparam logic [11:0] A2B_FLAT_FRONT [A2B_CELLS] =
    '{12'd617, 12'd548, 12'd480, 12'd411, 12'd340, 12'd274, 12'd205, 12'd137, 12'd69};
  localparam logic [11:0] A2B_FLAT_BACK [A2B_CELLS] =
    '{12'd1831, 12'd1902, 12'd1970, 12'd2039, 12'd2110, 12'd2176, 12'd2244, 12'd2313,
      12'd2381};
  localparam logic [11:0] A2B_STEEP_FRONT [A2B_CELLS+1] =
    '{12'd617, 12'd685, 12'd754, 12'd822, 12'd889, 12'd959, 12'd1028, 12'd1096,
      12'd1165, 12'd1225};
  localparam logic [11:0] A2B_STEEP_BACK [A2B_CELLS+1] =
    '{12'd1833, 12'd1765, 12'd1696, 12'd1628, 12'd1559, 12'd1493, 12'd1424, 12'd1356,
      12'd1287, 12'd1225};

  localparam logic [11:0] A2B_QUARTER = 12'd1225;
  localparam logic [11:0] A2B_HALF    = 12'd2450;

  function automatic logic signed [A2B_ANGLE_W-1:0] a2b_angle(input a2b_ctl_t c);
    logic [11:0] mag;
    logic        neg;
    mag = '0;
    neg = 1'b0;
    if (c.adj_zero) begin
      mag = A2B_QUARTER;
      neg = !c.opp_pos;
    end else if (c.opp_zero) begin
      mag = c.adj_pos ? 12'd0 : A2B_HALF;
    end else if (!c.steep) begin
      if (c.bucket >= A2B_BUCKET_W'(A2B_CELLS)) begin
        // far beyond the ladder: sign of opposite does not matter
        mag = c.adj_pos ? 12'd0 : A2B_HALF;
      end else begin
        mag = c.adj_pos ? A2B_FLAT_FRONT[c.bucket] : A2B_FLAT_BACK[c.bucket];
        neg = !c.opp_pos;
      end
    end else begin
      mag = c.adj_pos ? A2B_STEEP_FRONT[c.bucket] : A2B_STEEP_BACK[c.bucket];
      neg = !c.opp_pos;
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

FILE: sv/atan2_bucket_approximation.sv
// Channel | dir | tdata fields (low bit first)            | tuser/tlast
// in_     | in  | opposite[W-1:0], adjacent[W-1:0], pad 0s | none
// out_    | out | angle[12:0] signed, pad 0s to 16 bits    | none
//
// One item per cycle unless stalled; path: front stage, nine ladder cells, output register.
// The row of ladder cells sets the latency; each cell holds one ratio compare.
// Whole row holds while a result waits at the output and out_tready is low.
// rst_n (synchronous, active low) clears the valid bits only; in_tready is low during reset.
// Top level of the atan2 bucket approximation; depends on a2b_pkg, a2b_prep,
// a2b_cell, a2b_out and the assertion macro header.
`include "atan2_bucket_approximation_macros.svh"

module atan2_bucket_approximation import a2b_pkg::*; #(
  parameter  int INPUT_WIDTH = 16,
  localparam int IN_TDATA_W  = ((2 * INPUT_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_W-1:0]      in_tdata,   // opposite, adjacent, zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [A2B_OUT_TDATA_W-1:0] out_tdata   // angle, zero pad
);

  logic                          en;
  logic                          vld    [0:A2B_CELLS];
  a2b_ctl_t                      ctl    [0:A2B_CELLS];
  logic [INPUT_WIDTH-1:0]        mag_hi [0:A2B_CELLS];
  logic [INPUT_WIDTH-1:0]        mag_lo [0:A2B_CELLS];
  logic signed [A2B_ANGLE_W-1:0] angle;

  // advance unless a finished item is held at the output
  assign en        = !out_tvalid || out_tready;
  assign in_tready = rst_n && en;

  a2b_prep #(.INPUT_WIDTH(INPUT_WIDTH)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_tvalid),
    .opp_i    (in_tdata[INPUT_WIDTH-1:0]),
    .adj_i    (in_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
    .valid_o  (vld[0]),
    .ctl_o    (ctl[0]),
    .mag_hi_o (mag_hi[0]),
    .mag_lo_o (mag_lo[0])
  );

  for (genvar k = 0; k < A2B_CELLS; k++) begin : g_cell
    a2b_cell #(
      .INPUT_WIDTH (INPUT_WIDTH),
      .THRESH      (int'(A2B_LADDER[k]))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_i  (vld[k]),
      .ctl_i    (ctl[k]),
      .mag_hi_i (mag_hi[k]),
      .mag_lo_i (mag_lo[k]),
      .valid_o  (vld[k+1]),
      .ctl_o    (ctl[k+1]),
      .mag_hi_o (mag_hi[k+1]),
      .mag_lo_o (mag_lo[k+1])
    );
  end

  a2b_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vld[A2B_CELLS]),
    .ctl_i   (ctl[A2B_CELLS]),
    .valid_o (out_tvalid),
    .angle_o (angle)
  );

  assign out_tdata = {{(A2B_OUT_TDATA_W - A2B_ANGLE_W){1'b0}}, angle};

  `A2B_ASSERT_IMPLY(a_stall_ready, 1'b1, in_tready == !(out_tvalid && !out_tready))
  `A2B_ASSERT_IMPLY(a_angle_range, out_tvalid, (angle <= 13'sd2450) && (angle >= -13'sd2450))
  `A2B_ASSERT_IMPLY(a_no_neg_half, out_tvalid, angle != -13'sd2450)
  `A2B_ASSERT_NEXT(a_hold_result, out_tvalid && !out_tready, out_tvalid && !in_tready || out_tready)

endmodule

FILE: sv/a2b_prep.sv
// Front stage: magnitudes, signs and zero flags of one input item.
// Depends on a2b_pkg.
module a2b_prep import a2b_pkg::*; #(
  parameter int INPUT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic [INPUT_WIDTH-1:0] opp_i,
  input  logic [INPUT_WIDTH-1:0] adj_i,
  output logic                   valid_o,
  output a2b_ctl_t               ctl_o,
  output logic [INPUT_WIDTH-1:0] mag_hi_o,
  output logic [INPUT_WIDTH-1:0] mag_lo_o
);

  logic                   valid_r;
  a2b_ctl_t               ctl_r, ctl_nxt;
  logic [INPUT_WIDTH-1:0] mag_hi_r, mag_hi_nxt;
  logic [INPUT_WIDTH-1:0] mag_lo_r, mag_lo_nxt;
  logic [INPUT_WIDTH-1:0] mo, ma;

  always_comb begin
    // most negative input maps to 2^(W-1), which still fits unsigned
    mo = opp_i[INPUT_WIDTH-1] ? -opp_i : opp_i;
    ma = adj_i[INPUT_WIDTH-1] ? -adj_i : adj_i;
    ctl_nxt.opp_zero = (opp_i == '0);
    ctl_nxt.adj_zero = (adj_i == '0);
    ctl_nxt.opp_pos  = !opp_i[INPUT_WIDTH-1] && (opp_i != '0);
    ctl_nxt.adj_pos  = !adj_i[INPUT_WIDTH-1] && (adj_i != '0);
    ctl_nxt.steep    = !(ma > mo);
    ctl_nxt.bucket   = '0;
    mag_hi_nxt       = ctl_nxt.steep ? mo : ma;
    mag_lo_nxt       = ctl_nxt.steep ? ma : mo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r    <= ctl_nxt;
      mag_hi_r <= mag_hi_nxt;
      mag_lo_r <= mag_lo_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign ctl_o    = ctl_r;
  assign mag_hi_o = mag_hi_r;
  assign mag_lo_o = mag_lo_r;

endmodule

FILE: sv/a2b_cell.sv
// One ladder cell: tests 32*hi >= THRESH*lo and bumps the bucket on a pass.
// Depends on a2b_pkg.
module a2b_cell import a2b_pkg::*; #(
  parameter int          INPUT_WIDTH = 16,
  parameter int unsigned THRESH      = 35
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  a2b_ctl_t               ctl_i,
  input  logic [INPUT_WIDTH-1:0] mag_hi_i,
  input  logic [INPUT_WIDTH-1:0] mag_lo_i,
  output logic                   valid_o,
  output a2b_ctl_t               ctl_o,
  output logic [INPUT_WIDTH-1:0] mag_hi_o,
  output logic [INPUT_WIDTH-1:0] mag_lo_o
);

  localparam int CW = INPUT_WIDTH + 10;

  logic                   valid_r;
  a2b_ctl_t               ctl_r, ctl_nxt;
  logic [INPUT_WIDTH-1:0] mag_hi_r;
  logic [INPUT_WIDTH-1:0] mag_lo_r;
  logic [CW-1:0]          lhs, rhs;

  // floor(32*hi/lo) >= t  is the same as  32*hi >= t*lo
  always_comb begin
    lhs = {5'b0, mag_hi_i, 5'b0};
    rhs = CW'(mag_lo_i) * CW'(THRESH);
    ctl_nxt = ctl_i;
    if (lhs >= rhs) begin
      ctl_nxt.bucket = ctl_i.bucket + A2B_BUCKET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r    <= ctl_nxt;
      mag_hi_r <= mag_hi_i;
      mag_lo_r <= mag_lo_i;
    end
  end

  assign valid_o  = valid_r;
  assign ctl_o    = ctl_r;
  assign mag_hi_o = mag_hi_r;
  assign mag_lo_o = mag_lo_r;

endmodule

FILE: sv/a2b_out.sv
// Output register: angle table lookup from bucket and signs.
// Depends on a2b_pkg.
module a2b_out import a2b_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  a2b_ctl_t                      ctl_i,
  output logic                          valid_o,
  output logic signed [A2B_ANGLE_W-1:0] angle_o
);

  logic                          valid_r;
  logic signed [A2B_ANGLE_W-1:0] angle_r, angle_nxt;

  assign angle_nxt = a2b_angle(ctl_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign valid_o = valid_r;
  assign angle_o = angle_r;

endmodule

FILE: test/tb_atan2_bucket_approximation.sv
// Self-checking testbench for the atan2 bucket approximation stream block.
// Depends on a2b_pkg and atan2_bucket_approximation with its submodules and macro header.
`timescale 1ns / 1ps

module tb_atan2_bucket_approximation import a2b_pkg::*;;

  localparam int OPERAND_W  = 16;
  localparam int IN_TDATA_W = 32;
  localparam int ANGLE_W    = 13;
  localparam int RANDOM_ITEMS = 1000;

  localparam int QUARTER_TURN = 1225;
  localparam int HALF_TURN    = 2450;
  localparam int RATIO_SCALE  = 32;
  localparam int RUNGS        = 9;

  localparam int RATIO_RUNG [RUNGS] = '{35, 42, 51, 62, 78, 102, 145, 244, 733};
  localparam int SHALLOW_FWD [RUNGS] = '{617, 548, 480, 411, 340, 274, 205, 137, 69};
  localparam int SHALLOW_REV [RUNGS] =
    '{1831, 1902, 1970, 2039, 2110, 2176, 2244, 2313, 2381};
  localparam int STEEP_FWD [RUNGS+1] =
    '{617, 685, 754, 822, 889, 959, 1028, 1096, 1165, 1225};
  localparam int STEEP_REV [RUNGS+1] =
    '{1833, 1765, 1696, 1628, 1559, 1493, 1424, 1356, 1287, 1225};

  typedef logic signed [OPERAND_W-1:0] operand_t;
  typedef logic signed [ANGLE_W-1:0]   angle_t;

  typedef struct packed {
    operand_t opp;
    operand_t adj;
    logic     known;   // angle below is typed in, not predicted
    angle_t   angle;
  } vector_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam vector_row_t VECTOR_TABLE [DIRECTED_ROWS] = '{
    '{0,      0,      1, -1225},  // both zero: negative quarter turn
    '{5,      0,      1,  1225},
    '{-5,     0,      1, -1225},
    '{0,      7,      1,     0},
    '{0,      -7,     1,  2450},
    '{32767,  32767,  1,   617},  // equal magnitudes count as steep
    '{-32768, -32768, 1, -1833},
    '{1,      32767,  1,     0},  // shallow ratio beyond the ladder
    '{-1,     -32768, 1,  2450},
    '{32767,  1,      1,  1225},
    '{-32768, -1,     1, -1225},
    '{100,    -101,   1,  1831},  // first bucket, adjacent larger
    '{100,    -100,   1,  1833},  // first bucket, equal magnitudes
    '{-32768, 32767,  1,  -617},
    '{34,     32,     0,     0},
    '{35,     32,     0,     0},
    '{-32,    733,    1,     0},
    '{32,     -732,   0,     0},
    '{243,    -32,    0,     0},
    '{-244,   32,     0,     0},
    '{-32767, 0,      1, -1225},
    '{0,      -32768, 1,  2450}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [A2B_OUT_TDATA_W-1:0] out_tdata;

  // Travel alongside in_tdata so the monitor sees the row's typed angle
  logic   row_known = 1'b0;
  angle_t row_angle = '0;

  angle_t angles_due[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     stall_cycles = 0;
  int     gap_cycles = 0;

  atan2_bucket_approximation #(.INPUT_WIDTH(OPERAND_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic angle_t predict_angle(input operand_t opp, input operand_t adj);
    longint o, a, mo, ma, q;
    int     b;
    int     mag;
    o = opp;
    a = adj;
    if (a == 0) return angle_t'((o > 0) ? QUARTER_TURN : -QUARTER_TURN);
    if (o == 0) return angle_t'((a > 0) ? 0 : HALF_TURN);
    mo = (o < 0) ? -o : o;
    ma = (a < 0) ? -a : a;
    q = (ma > mo) ? (RATIO_SCALE * ma) / mo : (RATIO_SCALE * mo) / ma;
    b = 0;
    while (b < RUNGS && q >= RATIO_RUNG[b]) b++;
    if (ma > mo) begin
      // off the top of the ladder the sign of opposite is lost
      if (b >= RUNGS) return angle_t'((a > 0) ? 0 : HALF_TURN);
      mag = (a > 0) ? SHALLOW_FWD[b] : SHALLOW_REV[b];
    end else begin
      mag = (a > 0) ? STEEP_FWD[b] : STEEP_REV[b];
    end
    return angle_t'((o > 0) ? mag : -mag);
  endfunction

  // Record accepted items, check returned angles in order
  always @(posedge clk) begin
    angle_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        angles_due.push_back(row_known ? row_angle :
                             predict_angle(in_tdata[15:0], in_tdata[31:16]));
      if (out_tvalid && !out_tready) stall_cycles++;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (angles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result angle=%0d", $signed(out_tdata[ANGLE_W-1:0]));
        end else begin
          want = angles_due.pop_front();
          if (out_tdata[ANGLE_W-1:0] !== want ||
              out_tdata[A2B_OUT_TDATA_W-1:ANGLE_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d angle expected %0d got %0d (pad %b)",
                       results_seen, want, $signed(out_tdata[ANGLE_W-1:0]),
                       out_tdata[A2B_OUT_TDATA_W-1:ANGLE_W]);
          end
        end
      end
    end
  end

  // Receiver: switch at random between stall styles
  int ready_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  logic run_ready = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (mode_left % 4) != 3;
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 16);
          end else begin
            run_left--;
          end
          out_tready <= run_ready;
        end
      endcase
    end
  end

  task automatic send_vector(input operand_t opp, input operand_t adj,
                             input logic known, input angle_t angle);
    in_tvalid <= 1'b1;
    in_tdata  <= {adj, opp};
    row_known <= known;
    row_angle <= angle;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_off(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= $urandom;
    row_known <= 1'b0;
    repeat (cycles) begin
      @(posedge clk);
      gap_cycles++;
    end
  endtask

  task automatic make_vector(output operand_t opp, output operand_t adj);
    int kind, lo, hi, r;
    operand_t picks [6];
    picks = '{-32768, -32767, -1, 0, 1, 32767};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        opp = operand_t'($urandom);
        adj = operand_t'($urandom);
      end
      3, 4, 5: begin
        // ratio placed on either side of a ladder rung
        lo = $urandom_range(1, 1000);
        r  = RATIO_RUNG[$urandom_range(0, RUNGS - 1)] - 1 + $urandom_range(0, 2);
        hi = (r * lo + $urandom_range(0, RATIO_SCALE - 1)) / RATIO_SCALE;
        if (hi > 32767) hi = 32767;
        if ($urandom_range(0, 1)) begin
          opp = operand_t'(hi);
          adj = operand_t'(lo);
        end else begin
          opp = operand_t'(lo);
          adj = operand_t'(hi);
        end
        if ($urandom_range(0, 1)) opp = -opp;
        if ($urandom_range(0, 1)) adj = -adj;
      end
      6: begin
        opp = operand_t'($urandom);
        adj = operand_t'($urandom);
        if ($urandom_range(0, 1)) opp = '0;
        else adj = '0;
      end
      7: begin
        opp = operand_t'($urandom);
        adj = $urandom_range(0, 1) ? opp : -opp;
      end
      8: begin
        opp = operand_t'(int'($urandom_range(0, 16)) - 8);
        adj = operand_t'(int'($urandom_range(0, 16)) - 8);
      end
      default: begin
        opp = picks[$urandom_range(0, 5)];
        adj = picks[$urandom_range(0, 5)];
      end
    endcase
  endtask

  initial begin
    int       burst_left;
    operand_t opp, adj;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_vector(VECTOR_TABLE[i].opp, VECTOR_TABLE[i].adj,
                  VECTOR_TABLE[i].known, VECTOR_TABLE[i].angle);

    burst_left = $urandom_range(1, 30);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // drain the pipeline completely before carrying on
        in_tvalid <= 1'b0;
        row_known <= 1'b0;
        @(posedge clk);
        while (angles_due.size() != 0) @(posedge clk);
      end
      make_vector(opp, adj);
      send_vector(opp, adj, 1'b0, '0);
      if (--burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 30);
      end
    end
    in_tvalid <= 1'b0;
    row_known <= 1'b0;
    @(posedge clk);

    while (angles_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d table rows and %0d random operand pairs; %0d angles checked.",
             DIRECTED_ROWS, RANDOM_ITEMS, results_seen);
    $display("Sender idled %0d cycles, receiver stalled %0d; %0d mismatches.",
             gap_cycles, stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d angles outstanding", angles_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
